### design/aet_pkg.sv
// Shared constants, widths and divider request and response types for the envelope tracker.
`timescale 1ns / 1ps

package aet_pkg;

	// Field widths
	localparam int SMP_W  = 10;
	localparam int TIME_W = 32;
	localparam int HGT_W  = 10;
	localparam int MIN_W  = 11;
	localparam int CNT_W  = 16;
	localparam int INTV_W = 16;
	localparam int RATE_W = 16;

	// Converter scale and derived levels
	localparam int FULL_SCALE    = 1024;
	localparam int NEUTRAL_LEVEL = FULL_SCALE / 2;
	localparam int AMBIENT_START = NEUTRAL_LEVEL / 6;
	localparam int SLOW_WEIGHT   = 30;
	localparam int BG_ROUND      = (SLOW_WEIGHT + 2) / 2;
	localparam int RATE_SCALE    = 1000;
	localparam int INTV_RESET    = 1000;

	// Divider sizing: count * 1000 fits in 26 bits, ambient numerator in 14
	localparam int DIV_W      = 26;
	localparam int DIV_STEP_W = 5;
	localparam int BG_NUM_W   = 14;

	// Ambient divide by 31 as a reciprocal multiply, exact for 14-bit numerators
	localparam int BG_RECIP  = 16913;   // ceil(2^19 / 31)
	localparam int BG_SHIFT  = 19;
	localparam int BG_PROD_W = 29;

	// Request into the shared divider
	typedef struct packed {
		logic                  start;
		logic [DIV_W-1:0]      dividend;
		logic [TIME_W-1:0]     divisor;
		logic [DIV_STEP_W-1:0] steps;
	} div_req_t;

	// Response from the shared divider
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

### design/audio_envelope_tracker.sv
// Top level: sample request intake, reversal detection and envelope sequencer.
// From an accepted sample request to a valid result the sequencer passes the
// evaluation and output states; a reversal also passes the ambient and note
// states, the close state when it closes an interval, and before that the 26-step
// shared divider when a rate is computed. One sample at a time: intake reopens as
// the result is registered; a stalled result holds the next one. Reset (arst_n
// low, asynchronous) restores all tracker state and sets interval_ms to 1000.
`timescale 1ns / 1ps

module audio_envelope_tracker
	import aet_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // interval_ms
	// sample requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,     // sample[9:0], time_ms[41:10], zero pad
	// result requests
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,     // height_now, height_smoothed, ambient_level,
	                                 // prev_interval_min, prev_interval_max,
	                                 // waves_per_second, zero pad
	output logic        m_tuser      // is_reversal
);

	// Sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EVAL  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_RDIV  = 4'd3;
	localparam logic [3:0] ST_CLOSE = 4'd4;
	localparam logic [3:0] ST_BG    = 4'd5;
	localparam logic [3:0] ST_BDIV  = 4'd6;
	localparam logic [3:0] ST_NOTE  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	localparam logic [SMP_W-1:0] NEUTRAL = SMP_W'(NEUTRAL_LEVEL);
	localparam logic [HGT_W-1:0] AMB0    = HGT_W'(AMBIENT_START);
	localparam logic [MIN_W-1:0] FS_MIN  = MIN_W'(FULL_SCALE);

	logic [3:0] state_q;

	// Tracker state
	logic [INTV_W-1:0] interval_q;
	logic [SMP_W-1:0]  prev_q;
	logic              rising_q;
	logic              louder_q;
	logic [HGT_W-1:0]  wh_q;
	logic [HGT_W-1:0]  smooth_q;
	logic [HGT_W-1:0]  bg_q;
	logic [MIN_W-1:0]  run_min_q;
	logic [HGT_W-1:0]  run_max_q;
	logic [MIN_W-1:0]  last_min_q;
	logic [HGT_W-1:0]  last_max_q;
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] start_q;
	logic [RATE_W-1:0] rate_q;

	// Per-sample working registers
	logic [SMP_W-1:0]    cur_q;
	logic [TIME_W-1:0]   now_q;
	logic                rev_q;
	logic [HGT_W-1:0]    h_q;
	logic [BG_NUM_W-1:0] bg_num_q;

	// Output register
	logic              m_tvalid_q;
	logic [71:0]       m_tdata_q;
	logic              m_tuser_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              peak;
	logic              trough;
	logic [HGT_W-1:0]  h_new;
	logic [TIME_W:0]   limit;
	logic              close_now;
	logic              rate_go;
	logic              bg_go;
	logic [BG_NUM_W-1:0] bg_num;
	logic [BG_PROD_W-1:0] bg_prod;
	logic [HGT_W:0]    smooth_sum;
	logic [HGT_W-1:0]  smooth_new;
	logic [RATE_W-1:0] rate_sat;
	logic              out_free;

	// Reversal and interval decisions
	always_comb begin
		peak      = rising_q && (prev_q > NEUTRAL) && (cur_q < prev_q);
		trough    = (prev_q < NEUTRAL) && !rising_q && (cur_q > prev_q);
		h_new     = (prev_q > NEUTRAL) ? prev_q - NEUTRAL : NEUTRAL - prev_q;
		limit     = {1'b0, start_q} + {{(TIME_W+1-INTV_W){1'b0}}, interval_q};
		close_now = (now_q < start_q) || ({1'b0, now_q} > limit);
		rate_go   = (start_q != '0) && (now_q > start_q);
		bg_go     = !louder_q && (h_q > wh_q);
	end

	// Ambient numerator and reciprocal, smoothing and rate saturation
	always_comb begin
		bg_num     = BG_NUM_W'(wh_q) + BG_NUM_W'(bg_q) * BG_NUM_W'(SLOW_WEIGHT)
		           + BG_NUM_W'(BG_ROUND);
		bg_prod    = BG_PROD_W'(bg_num_q) * BG_PROD_W'(BG_RECIP);
		smooth_sum = {1'b0, h_q} + {1'b0, smooth_q} + (HGT_W+1)'(1);
		smooth_new = smooth_sum[HGT_W:1];
		rate_sat   = (|div_rsp.quotient[DIV_W-1:RATE_W]) ? '1
		                                                 : div_rsp.quotient[RATE_W-1:0];
		out_free   = !m_tvalid_q || m_tready;
	end

	// Divider requests
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_MUL: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(count_q) * DIV_W'(RATE_SCALE);
				div_req.divisor  = now_q - start_q;
				div_req.steps    = DIV_STEP_W'(DIV_W);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	aet_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTV_W'(INTV_RESET);
		end else if (cfg_we) begin
			interval_q <= cfg_wdata;
		end
	end

	// Sequencer and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prev_q     <= NEUTRAL;
			rising_q   <= 1'b0;
			louder_q   <= 1'b0;
			wh_q       <= AMB0;
			smooth_q   <= AMB0;
			bg_q       <= AMB0;
			run_min_q  <= FS_MIN;
			run_max_q  <= '0;
			last_min_q <= MIN_W'(AMBIENT_START);
			last_max_q <= AMB0;
			count_q    <= '0;
			start_q    <= '0;
			rate_q     <= '0;
			rev_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					rev_q    <= peak || trough;
					rising_q <= cur_q > prev_q;
					prev_q   <= cur_q;
					if (peak && (count_q != '1)) begin
						count_q <= count_q + 1'b1;
					end
					if (!(peak || trough)) begin
						state_q <= ST_OUT;
					end else if (close_now && rate_go) begin
						state_q <= ST_MUL;
					end else if (close_now) begin
						state_q <= ST_CLOSE;
					end else begin
						state_q <= ST_BG;
					end
				end
				ST_MUL: begin
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					if (div_rsp.done) begin
						rate_q  <= rate_sat;
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					count_q <= '0;
					if (run_min_q < FS_MIN) begin
						last_min_q <= run_min_q;
					end
					run_min_q <= FS_MIN;
					if (run_max_q != '0) begin
						last_max_q <= run_max_q;
					end
					run_max_q <= '0;
					start_q   <= now_q;
					state_q   <= ST_BG;
				end
				ST_BG: begin
					state_q <= bg_go ? ST_BDIV : ST_NOTE;
				end
				// Ambient quotient from the registered numerator
				ST_BDIV: begin
					bg_q    <= bg_prod[BG_SHIFT +: HGT_W];
					state_q <= ST_NOTE;
				end
				ST_NOTE: begin
					louder_q <= h_q > wh_q;
					wh_q     <= h_q;
					smooth_q <= smooth_new;
					if ({1'b0, smooth_new} < run_min_q) begin
						run_min_q <= {1'b0, smooth_new};
					end
					if (smooth_new > run_max_q) begin
						run_max_q <= smooth_new;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result valid: set as a result is registered, cleared when it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Sample capture, per-reversal height and ambient numerator
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cur_q <= s_tdata[9:0];
			now_q <= s_tdata[41:10];
		end
		if (state_q == ST_EVAL) begin
			h_q <= h_new;
		end
		if (state_q == ST_BG) begin
			bg_num_q <= bg_num;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_tuser_q <= rev_q;
			m_tdata_q <= {5'b0, rate_q, last_max_q, last_min_q, bg_q, smooth_q, wh_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### design/aet_div.sv
// Shared restoring divider, one quotient bit per cycle, MSB first.
`timescale 1ns / 1ps

module aet_div
	import aet_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [TIME_W-1:0]     rem_q;
	logic [DIV_W-1:0]      dvd_q;
	logic [TIME_W-1:0]     dvs_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [TIME_W:0] shifted;
	logic            ge;
	logic [TIME_W:0] diff;
	logic            last_step;

	// One trial subtraction per cycle
	always_comb begin
		shifted   = {rem_q, dvd_q[DIV_W-1]};
		ge        = shifted >= {1'b0, dvs_q};
		diff      = shifted - {1'b0, dvs_q};
		last_step = busy_q && !req.start && (cnt_q == DIV_STEP_W'(1));
	end

	// Control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: partial remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

### design/aet_checker.sv
// Port-level checks for the envelope tracker, bound to the top level.
`timescale 1ns / 1ps

module aet_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser
);

	// One sample at a time: intake closes right after a request is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("intake stayed open after a sample request");

	// Every field of an offered result is driven
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
		else $error("unknown result field");

	// Heights stay within half of full scale
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:0] <= 10'd512 && m_tdata[19:10] <= 10'd512 &&
		              m_tdata[29:20] <= 10'd512 && m_tdata[50:41] <= 10'd512))
		else $error("height field above half scale");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind audio_envelope_tracker aet_checker u_aet_checker (.*);

### tb/testbench.sv
// Self-checking testbench for the audio envelope tracker stream block.
`timescale 1ns / 1ps

module testbench;
	import aet_pkg::*;

	// Expected result of one sample request
	typedef struct packed {
		logic              rev;
		logic [HGT_W-1:0]  hnow;
		logic [HGT_W-1:0]  hsmooth;
		logic [HGT_W-1:0]  ambient;
		logic [MIN_W-1:0]  pmin;
		logic [HGT_W-1:0]  pmax;
		logic [RATE_W-1:0] rate;
	} envelope_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = 48'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;

	logic [47:0] sample_backlog[$];
	envelope_t   envelope_due[$];
	int unsigned errors = 0;
	logic [31:0] gen_time = 32'd0;
	bit          steady = 1'b0;
	int unsigned burst_left = 0, gap_left = 0;
	int unsigned hold_ticket = 0, hold_seen = 0, hold_left = 0;
	int unsigned rx_count = 0, rx_mode = 0;

	// Tracker state mirrored by the predictor
	int unsigned trk_interval, trk_prev, trk_height, trk_smooth, trk_ambient;
	int unsigned trk_run_min, trk_run_max, trk_last_min, trk_last_max;
	int unsigned trk_waves, trk_rate;
	bit          trk_rising, trk_louder;
	logic [31:0] trk_start;

	audio_envelope_tracker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic void reset_tracker();
		trk_interval = INTV_RESET;
		trk_prev     = NEUTRAL_LEVEL;
		trk_rising   = 1'b0;
		trk_louder   = 1'b0;
		trk_height   = AMBIENT_START;
		trk_smooth   = AMBIENT_START;
		trk_ambient  = AMBIENT_START;
		trk_run_min  = FULL_SCALE;
		trk_run_max  = 0;
		trk_last_min = AMBIENT_START;
		trk_last_max = AMBIENT_START;
		trk_waves    = 0;
		trk_start    = 32'd0;
		trk_rate     = 0;
	endfunction

	// Advance the tracker by one sample and return the envelope it reports
	function automatic envelope_t predict_envelope(logic [SMP_W-1:0] cur_s,
		logic [TIME_W-1:0] now_t);
		envelope_t         r;
		bit                rev;
		int unsigned       cur, prv, h;
		longint unsigned   now, lim, q;
		cur = 32'(cur_s);
		now = 64'(now_t);
		prv = trk_prev;
		rev = 1'b0;
		if (trk_rising && prv > NEUTRAL_LEVEL && cur < prv) begin
			if (trk_waves < 32'hFFFF)
				trk_waves++;
			rev = 1'b1;
		end else if (prv < NEUTRAL_LEVEL && !trk_rising && cur > prv) begin
			rev = 1'b1;
		end
		if (rev) begin
			// interval close: elapsed (33-bit sum) or time wrapped
			lim = longint'(trk_start) + longint'(trk_interval);
			if (now < trk_start || now > lim) begin
				if (trk_start != 0 && now > trk_start) begin
					q = (longint'(trk_waves) * RATE_SCALE) / (now - trk_start);
					trk_rate = (q > 64'hFFFF) ? 32'hFFFF : int'(q);
				end
				trk_waves = 0;
				if (trk_run_min < FULL_SCALE)
					trk_last_min = trk_run_min;
				trk_run_min = FULL_SCALE;
				if (trk_run_max > 0)
					trk_last_max = trk_run_max;
				trk_run_max = 0;
				trk_start = now_t;
			end
			// height update from the previous sample
			h = (prv > NEUTRAL_LEVEL) ? prv - NEUTRAL_LEVEL : NEUTRAL_LEVEL - prv;
			if (!trk_louder && h > trk_height)
				trk_ambient = (trk_height + trk_ambient * SLOW_WEIGHT + BG_ROUND)
					/ (SLOW_WEIGHT + 1);
			trk_louder = h > trk_height;
			trk_height = h;
			trk_smooth = (trk_height + trk_smooth + 1) / 2;
			if (trk_smooth < trk_run_min)
				trk_run_min = trk_smooth;
			if (trk_smooth > trk_run_max)
				trk_run_max = trk_smooth;
		end
		trk_rising = cur > prv;
		trk_prev   = cur;
		r.rev     = rev;
		r.hnow    = trk_height[HGT_W-1:0];
		r.hsmooth = trk_smooth[HGT_W-1:0];
		r.ambient = trk_ambient[HGT_W-1:0];
		r.pmin    = trk_last_min[MIN_W-1:0];
		r.pmax    = trk_last_max[HGT_W-1:0];
		r.rate    = trk_rate[RATE_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Sample driver: bursts with random gaps, fed from the backlog
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 48'd0;
		end else begin
			if (s_tvalid && s_tready)
				envelope_due.push_back(predict_envelope(s_tdata[SMP_W-1:0],
					s_tdata[SMP_W +: TIME_W]));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0 && !steady) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (sample_backlog.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= sample_backlog.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: long hold on request, otherwise a randomly chosen stall pattern
	always @(posedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= 400;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			rx_count <= rx_count + 1;
			if (rx_count % 97 == 0)
				rx_mode <= $urandom_range(0, 3);
			if (steady)
				m_tready <= 1'b1;
			else case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_count % 5 != 0);
			endcase
		end
	end

	// Result checker
	always @(posedge clk) begin
		envelope_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (envelope_due.size() == 0) begin
				$error("result with no sample pending");
				errors++;
			end else begin
				want = envelope_due.pop_front();
				check_field("is_reversal", 32'(want.rev), 32'(m_tuser));
				check_field("height_now", 32'(want.hnow), 32'(m_tdata[9:0]));
				check_field("height_smoothed", 32'(want.hsmooth), 32'(m_tdata[19:10]));
				check_field("ambient_level", 32'(want.ambient), 32'(m_tdata[29:20]));
				check_field("prev_interval_min", 32'(want.pmin), 32'(m_tdata[40:30]));
				check_field("prev_interval_max", 32'(want.pmax), 32'(m_tdata[50:41]));
				check_field("waves_per_second", 32'(want.rate), 32'(m_tdata[66:51]));
			end
		end
	end

	task automatic queue_sample(int unsigned v, int unsigned step);
		gen_time = gen_time + $urandom_range(0, step);
		sample_backlog.push_back({6'd0, gen_time, v[SMP_W-1:0]});
	endtask

	task automatic queue_at(int unsigned v, logic [31:0] t);
		gen_time = t;
		sample_backlog.push_back({6'd0, t, v[SMP_W-1:0]});
	endtask

	// Waveform bursts around mid-scale with noise, time jumps and wraps
	task automatic add_waves(int unsigned n, int unsigned max_step);
		int unsigned done_n, pick, hi, lo, half, k;
		done_n = 0;
		while (done_n < n) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				queue_sample($urandom_range(0, 1023), max_step);
				done_n++;
			end else if (pick == 1) begin
				gen_time = $urandom();
			end else if (pick == 2) begin
				gen_time = 32'hFFFF_FFFF - $urandom_range(0, 3 * max_step + 3);
			end else begin
				hi = NEUTRAL_LEVEL + (($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 12) : $urandom_range(1, 511));
				lo = NEUTRAL_LEVEL - (($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 12) : $urandom_range(1, 512));
				half = $urandom_range(1, 5);
				for (k = 1; k <= half; k++)
					queue_sample(lo + (hi - lo) * k / half, max_step);
				for (k = 1; k <= half; k++)
					queue_sample(hi - (hi - lo) * k / half, max_step);
				done_n += 2 * half;
			end
		end
	endtask

	// Square wave at one timestamp: from the third sample on, every sample is a reversal
	task automatic add_square(int unsigned n, logic [31:0] t);
		int unsigned k;
		for (k = 0; k < n; k++)
			queue_at((k % 2 == 0) ? 1023 : 0, t);
	endtask

	// Wait until the block is idle, then let its longest latency pass
	task automatic drain();
		while (sample_backlog.size() != 0 || s_tvalid || envelope_due.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_interval(logic [15:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		trk_interval = 32'(v);
		@(negedge clk);
	endtask

	initial begin
		reset_tracker();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: first peak, close from zero start, elapsed close, wrap
		queue_at(512, 0);
		queue_at(1023, 1);
		queue_at(0, 2);
		queue_at(1023, 3);
		queue_at(0, 5000);
		queue_at(1023, 5001);
		queue_at(0, 5002);
		queue_at(700, 5003);
		queue_at(600, 5004);
		queue_at(511, 5005);
		queue_at(512, 5006);
		queue_at(513, 5007);
		queue_at(512, 7000);
		queue_at(1023, 32'hFFFF_FFF0);
		queue_at(0, 32'hFFFF_FFF1);
		queue_at(1023, 32'hFFFF_FFFF);
		queue_at(0, 4);
		queue_at(0, 4);
		queue_at(1023, 4);
		drain();

		// Shortest nonzero interval
		write_interval(16'd1);
		add_waves(150, 3);
		drain();

		// Zero interval with rate saturation
		write_interval(16'd0);
		add_square(140, gen_time + 10);
		add_square(4, gen_time + 1);
		add_waves(80, 2);
		drain();

		// Longest interval near the top of time; long result hold
		write_interval(16'hFFFF);
		gen_time = 32'hFFFF_FF00;
		add_square(6, gen_time);
		add_square(4, 32'hFFFF_FFFF);
		add_waves(150, 500);
		@(negedge clk);
		hold_ticket++;
		drain();

		// No idling on either side
		write_interval(16'd20);
		steady = 1'b1;
		add_waves(150, 8);
		drain();
		steady = 1'b0;

		write_interval(16'd250);
		add_waves(150, 40);
		drain();

		write_interval(16'($urandom_range(1, 65535)));
		add_waves(150, $urandom_range(1, 2000));
		drain();

		if (envelope_due.size() != 0) begin
			$error("%0d results never arrived", envelope_due.size());
			errors++;
		end
		if (errors == 0)
			$display("[audio_envelope_tracker] OK");
		else
			$display("[audio_envelope_tracker] ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[audio_envelope_tracker] ERROR");
		$finish;
	end

endmodule

### files.f
design/aet_pkg.sv
design/aet_div.sv
design/audio_envelope_tracker.sv
design/aet_checker.sv
tb/testbench.sv
